/* rtl/core/mtbd_pkg.sv */
// ----------------------------------------------------------------------------
// mtbd_pkg
// Shared constants, types and trig/phase tables of the multitone byte
// demodulator.
// ----------------------------------------------------------------------------
package mtbd_pkg;

  // Segment and bin configuration
  localparam int SEGMENT_LENGTH = 32;
  localparam int TONE_BINS      = 8;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int THRESH_W   = 15;
  localparam int CHAR_W     = 8;
  localparam int CHAR_IDX_W = 3;
  localparam int ACC_W      = 40;
  localparam int TRIG_W     = 16;
  localparam int PHASE_W    = 5;
  localparam int PHASE_N    = 32;
  localparam int MAG_SHIFT  = 15;
  localparam int MAG_W      = 24;
  localparam int OPND_W     = MAG_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int SQ_W       = 2 * MAG_W;

  // Derived counter widths
  localparam int POS_W   = $clog2(SEGMENT_LENGTH);
  localparam int BIN_W   = (TONE_BINS > 1) ? $clog2(TONE_BINS) : 1;
  localparam int STEPS   = 2 * TONE_BINS;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int LIMIT_W = THRESH_W + POS_W + 1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(2000);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_LIMIT,
    ST_SQUARE,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // What to do with a product once it leaves the multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC_RE,
    OP_ACC_IM,
    OP_LIMIT,
    OP_SQ_A,
    OP_SQ_B
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] bin;
  } mult_tag_t;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef trig_t sine_table_t [PHASE_N];
  typedef logic [PHASE_W-1:0] phase_t;
  typedef phase_t phase_table_t [SEGMENT_LENGTH];

  // Full circle of 32 sine steps in Q1.15
  function automatic sine_table_t build_sine();
    int quarter [9] = '{0, 6393, 12539, 18204, 23170, 27245, 30273, 32137, 32767};
    sine_table_t t;
    int r;
    int v;
    for (int p = 0; p < PHASE_N; p++) begin
      r = p % 16;
      v = (r <= 8) ? quarter[r] : quarter[16 - r];
      t[p] = trig_t'((p >= 16) ? -v : v);
    end
    return t;
  endfunction

  // Segment phase to circle step, rounded
  function automatic phase_table_t build_phase();
    phase_table_t t;
    for (int m = 0; m < SEGMENT_LENGTH; m++) begin
      t[m] = phase_t'(((m * 64 + SEGMENT_LENGTH) / (2 * SEGMENT_LENGTH)) % PHASE_N);
    end
    return t;
  endfunction

  localparam sine_table_t  SINE_TABLE  = build_sine();
  localparam phase_table_t PHASE_TABLE = build_phase();

endpackage

/* rtl/core/mtbd_sample_if.sv */
// ----------------------------------------------------------------------------
// mtbd_sample_if
// Valid/ready channel that carries one signed audio sample per request.
// ----------------------------------------------------------------------------
interface mtbd_sample_if import mtbd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/core/mtbd_char_if.sv */
// ----------------------------------------------------------------------------
// mtbd_char_if
// Valid/ready channel that carries one decoded character per request.
// ----------------------------------------------------------------------------
interface mtbd_char_if import mtbd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

/* rtl/core/multitone_byte_demodulator.sv */
// ----------------------------------------------------------------------------
// multitone_byte_demodulator
// Eight-bin odd-harmonic DFT tone detector. Correlates each segment of
// samples against cosine and sine, then thresholds each bin magnitude to
// form one character per segment.
// ----------------------------------------------------------------------------
//
//  channel      dir  payload                 handshake
//  samples      in   sample    (s16)         valid / ready
//  characters   out  character (u8)          valid / ready
//  cfg_write_*  in   magnitude_threshold u15 write enable, no wait
//
//  A sample is taken in ST_IDLE, then multiply-accumulated with the cosine
//  and sine of every bin on the shared multiplier; no new sample is taken
//  meanwhile. After a segment's last sample, ST_LIMIT, ST_SQUARE and
//  ST_DRAIN square the sums on it, and ST_OUT loads the character register.
//  Reset is synchronous: sums, position and threshold go to their
//  initial values at once. A stalled character holds in the output
//  register; the block stalls only if a second character is ready first.
// ----------------------------------------------------------------------------
module multitone_byte_demodulator import mtbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  mtbd_sample_if.sink         samples,
  mtbd_char_if.source         characters,
  input  logic                cfg_write_enable,
  input  logic [THRESH_W-1:0] cfg_write_data
);

  state_t                     state, state_next;
  logic [STEP_W-1:0]          step, step_next;
  logic [POS_W-1:0]           pos;
  logic                       last_q;
  logic [POS_W-1:0]           phase_m;
  logic [POS_W-1:0]           delta;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [THRESH_W-1:0]        thresh;
  logic signed [ACC_W-1:0]    re_sum [TONE_BINS];
  logic signed [ACC_W-1:0]    im_sum [TONE_BINS];
  logic [SQ_W-1:0]            mag_part;
  logic [SQ_W-1:0]            limit_sq;
  logic [CHAR_W-1:0]          char_bits;
  logic                       out_valid;
  logic [CHAR_W-1:0]          out_char;

  logic                       accept;
  logic                       out_load;
  logic                       last_step;
  logic                       advance_phase;
  logic [BIN_W-1:0]           bin_sel;
  logic signed [OPND_W-1:0]   opnd_a, opnd_b;
  mult_tag_t                  tag_in, tag_out;
  logic signed [PROD_W-1:0]   product;

  logic [POS_W:0]             two_n;
  logic [POS_W:0]             m_sum;
  phase_t                     phase_p;
  trig_t                      trig;
  logic signed [ACC_W-1:0]    sq_src;
  logic [ACC_W-1:0]           sq_abs;
  logic [MAG_W-1:0]           mag;
  logic [LIMIT_W-1:0]         limit;
  logic [SQ_W:0]              mag_total;
  logic [CHAR_IDX_W-1:0]      char_idx;

  assign samples.ready        = (state == ST_IDLE);
  assign accept               = samples.valid && samples.ready;
  assign characters.valid     = out_valid;
  assign characters.character = out_char;

  assign last_step = (step == STEP_W'(STEPS - 1));
  assign bin_sel   = BIN_W'(step >> 1);
  assign out_load  = (state == ST_OUT) && (!out_valid || characters.ready);

  // Phase lookup for the bin in work
  assign phase_p = PHASE_TABLE[phase_m];
  assign trig    = step[0] ? SINE_TABLE[phase_p] : SINE_TABLE[phase_p + PHASE_W'(8)];

  // Magnitude in sample units for the square pass
  assign sq_src = step[0] ? im_sum[bin_sel] : re_sum[bin_sel];
  assign sq_abs = sq_src[ACC_W-1] ? ACC_W'(-sq_src) : ACC_W'(sq_src);
  assign mag    = sq_abs[MAG_W+MAG_SHIFT-1:MAG_SHIFT];
  assign limit  = LIMIT_W'(thresh) * LIMIT_W'(SEGMENT_LENGTH);

  // Twice the position, folded once into the segment
  assign two_n = {pos, 1'b0};
  assign m_sum = {1'b0, phase_m} + {1'b0, delta};

  // Sequencer: next state and multiplier issue
  always_comb begin
    state_next    = state;
    step_next     = step;
    advance_phase = 1'b0;
    opnd_a        = '0;
    opnd_b        = '0;
    tag_in        = '{op: OP_NONE, bin: bin_sel};
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (accept) state_next = ST_MAC;
      end
      ST_MAC: begin
        opnd_a        = OPND_W'(sample_q);
        opnd_b        = OPND_W'(trig);
        tag_in.op     = step[0] ? OP_ACC_IM : OP_ACC_RE;
        advance_phase = step[0];
        step_next     = step + STEP_W'(1);
        if (last_step) begin
          step_next  = '0;
          state_next = last_q ? ST_LIMIT : ST_IDLE;
        end
      end
      ST_LIMIT: begin
        opnd_a     = OPND_W'(limit);
        opnd_b     = OPND_W'(limit);
        tag_in.op  = OP_LIMIT;
        step_next  = '0;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        opnd_a    = OPND_W'(mag);
        opnd_b    = OPND_W'(mag);
        tag_in.op = step[0] ? OP_SQ_B : OP_SQ_A;
        step_next = step + STEP_W'(1);
        if (last_step) begin
          step_next  = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Track segment position and per-sample phase stepping
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      last_q <= 1'b0;
    end else if (accept) begin
      last_q <= (pos == POS_W'(SEGMENT_LENGTH - 1));
      pos    <= (pos == POS_W'(SEGMENT_LENGTH - 1)) ? '0 : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= samples.sample;
      phase_m  <= pos;
      delta    <= (two_n >= (POS_W+1)'(SEGMENT_LENGTH))
                  ? POS_W'(two_n - (POS_W+1)'(SEGMENT_LENGTH)) : POS_W'(two_n);
    end else if (advance_phase) begin
      phase_m  <= (m_sum >= (POS_W+1)'(SEGMENT_LENGTH))
                  ? POS_W'(m_sum - (POS_W+1)'(SEGMENT_LENGTH)) : POS_W'(m_sum);
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_write_enable) begin
      thresh <= cfg_write_data;
    end
  end

  mtbd_shared_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .opnd_a  (opnd_a),
    .opnd_b  (opnd_b),
    .tag_in  (tag_in),
    .product (product),
    .tag_out (tag_out)
  );

  assign mag_total = {1'b0, mag_part} + {1'b0, product[SQ_W-1:0]};
  assign char_idx  = CHAR_IDX_W'(CHAR_W - 1) - CHAR_IDX_W'(tag_out.bin);

  // Accumulate products into the bin sums; clear them once a character is loaded for output
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      for (int j = 0; j < TONE_BINS; j++) begin
        re_sum[j] <= '0;
        im_sum[j] <= '0;
      end
    end else begin
      case (tag_out.op)
        OP_ACC_RE: re_sum[tag_out.bin] <= re_sum[tag_out.bin] + ACC_W'(product);
        OP_ACC_IM: im_sum[tag_out.bin] <= im_sum[tag_out.bin] - ACC_W'(product);
        default: ;
      endcase
    end
  end

  // Magnitude test per bin
  always_ff @(posedge clk) begin
    if (state == ST_LIMIT) begin
      char_bits <= '0;
    end
    case (tag_out.op)
      OP_LIMIT: limit_sq <= product[SQ_W-1:0];
      OP_SQ_A:  mag_part <= product[SQ_W-1:0];
      OP_SQ_B:  char_bits[char_idx] <= (mag_total > {1'b0, limit_sq});
      default: ;
    endcase
  end

  // Output register: load a finished character, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (characters.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= char_bits;
    end
  end

endmodule

/* rtl/core/mtbd_shared_mult.sv */
// ----------------------------------------------------------------------------
// mtbd_shared_mult
// Single signed multiplier shared by the correlation and magnitude passes.
// Registers the product together with a tag that tells the consumer where
// the product goes.
// ----------------------------------------------------------------------------
module mtbd_shared_mult import mtbd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [OPND_W-1:0] opnd_a,
  input  logic signed [OPND_W-1:0] opnd_b,
  input  mult_tag_t                tag_in,
  output logic signed [PROD_W-1:0] product,
  output mult_tag_t                tag_out
);

  // Multiply and register the product
  always_ff @(posedge clk) begin
    product <= opnd_a * opnd_b;
  end

  // Carry the tag alongside; clear it on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '{op: OP_NONE, bin: '0};
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

/* tb/mtbd_char_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_char_checker
// Watches the sample and character channels and the threshold write port,
// keeps its own eight-bin correlation sums, predicts each decoded character
// and compares it against what the block delivers.
// ----------------------------------------------------------------------------
module mtbd_char_checker import mtbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  mtbd_sample_if              samples,
  mtbd_char_if                characters,
  input  logic                cfg_write_enable,
  input  logic [THRESH_W-1:0] cfg_write_data,
  output int                  failures,
  output int                  pending
);

  localparam int REPORT_LIMIT = 10;
  localparam int QUARTER_SINE [9] = '{0, 6393, 12539, 18204, 23170, 27245, 30273,
                                      32137, 32767};

  logic [THRESH_W-1:0] threshold;
  int                  position;
  longint              real_acc [TONE_BINS];
  longint              imag_acc [TONE_BINS];
  logic [CHAR_W-1:0]   expected_chars [$];

  // Q1.15 sine on a 32-step circle
  function automatic int circle_sine(int p);
    int r;
    int v;
    p = p & (PHASE_N - 1);
    r = p % 16;
    v = (r <= 8) ? QUARTER_SINE[r] : QUARTER_SINE[16 - r];
    return (p >= 16) ? -v : v;
  endfunction

  // Threshold every bin magnitude against the limit scaled by the segment length
  function automatic logic [CHAR_W-1:0] decide_character();
    logic [CHAR_W-1:0] ch;
    longint            a;
    longint            b;
    longint            limit;
    ch    = '0;
    limit = longint'(threshold) * SEGMENT_LENGTH;
    for (int j = 0; j < TONE_BINS; j++) begin
      a = ((real_acc[j] < 0) ? -real_acc[j] : real_acc[j]) >> MAG_SHIFT;
      b = ((imag_acc[j] < 0) ? -imag_acc[j] : imag_acc[j]) >> MAG_SHIFT;
      if (a * a + b * b > limit * limit) ch[CHAR_W-1-j] = 1'b1;
    end
    return ch;
  endfunction

  // Accumulate one sample into every bin; close the segment on its last one
  task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s);
    int k;
    int m;
    int p;
    for (int j = 0; j < TONE_BINS; j++) begin
      k = 2 * j + 1;
      m = (k * position) % SEGMENT_LENGTH;
      p = (m * 64 + SEGMENT_LENGTH) / (2 * SEGMENT_LENGTH);
      real_acc[j] += longint'(int'(s) * circle_sine(p + 8));
      imag_acc[j] -= longint'(int'(s) * circle_sine(p));
    end
    if (position == SEGMENT_LENGTH - 1) begin
      expected_chars.push_back(decide_character());
      for (int j = 0; j < TONE_BINS; j++) begin
        real_acc[j] = 0;
        imag_acc[j] = 0;
      end
      position = 0;
    end else begin
      position++;
    end
  endtask

  // Compare a delivered character with the oldest prediction
  task automatic check_character(input logic [CHAR_W-1:0] got);
    logic [CHAR_W-1:0] want;
    if (expected_chars.size() == 0) begin
      if (failures < REPORT_LIMIT) $display("unexpected character %02h", got);
      failures++;
    end else begin
      want = expected_chars.pop_front();
      if (got !== want) begin
        if (failures < REPORT_LIMIT) begin
          $display("character mismatch: expected %02h, got %02h", want, got);
        end
        failures++;
      end
    end
  endtask

  // Track requests on every rising edge
  always @(posedge clk) begin
    if (rst) begin
      threshold = THRESH_RESET;
      position  = 0;
      failures  = 0;
      for (int j = 0; j < TONE_BINS; j++) begin
        real_acc[j] = 0;
        imag_acc[j] = 0;
      end
      expected_chars.delete();
    end else begin
      if (characters.valid && characters.ready) check_character(characters.character);
      if (samples.valid && samples.ready) absorb_sample(samples.sample);
      if (cfg_write_enable) threshold = cfg_write_data;
    end
    pending = expected_chars.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives segments of audio samples into the multitone byte demodulator:
// a directed set of constant, impulse and tone segments around the
// threshold boundaries, then random multi-tone, noise and full-scale
// segments under changing thresholds and back-pressure. A separate checker
// predicts and compares the characters; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench import mtbd_pkg::*;;

  localparam int CYCLE_LIMIT          = 300000;
  localparam int SETTLE_CYCLES        = 64;
  localparam int LONG_STALL           = 2500;
  localparam int SEGMENTS_PER_PHASE   = 9;
  localparam int SEGMENTS_PER_SETTING = 4;
  localparam int DRAIN_LIMIT          = 20000;

  typedef enum int {
    SEG_TONE,
    SEG_NOISE,
    SEG_FULL_SCALE
  } segment_kind_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write_enable;
  logic [THRESH_W-1:0] cfg_write_data;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_requests;
  int cycle_count;
  int chk_failures;
  int chk_pending;
  int tone_amp [TONE_BINS];
  int tone_phase [TONE_BINS];

  mtbd_sample_if samples_ch ();
  mtbd_char_if   chars_ch ();

  multitone_byte_demodulator dut (
    .clk              (clk),
    .rst              (rst),
    .samples          (samples_ch),
    .characters       (chars_ch),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  mtbd_char_checker char_check (
    .clk              (clk),
    .rst              (rst),
    .samples          (samples_ch),
    .characters       (chars_ch),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .failures         (chk_failures),
    .pending          (chk_pending)
  );

  // Clock
  always #5 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Character sink: random idling, plus long hold-offs on request
  initial begin : char_sink
    int holds_done;
    holds_done     = 0;
    chars_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < stall_requests) begin
        holds_done++;
        chars_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end else begin
        chars_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  // Offer one sample request and hold it until accepted
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(negedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= s;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the threshold once the block has gone quiet
  task automatic set_threshold(input logic [THRESH_W-1:0] value);
    samples_ch.valid <= 1'b0;
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // Sum of the loaded tones at sample n, with optional noise, clamped
  function automatic logic signed [SAMPLE_W-1:0] tone_sample(int n, int noise);
    int acc;
    acc = 0;
    for (int j = 0; j < TONE_BINS; j++) begin
      acc += tone_amp[j] * SINE_TABLE[((2 * j + 1) * n + tone_phase[j] + 8) % PHASE_N]
             / 32768;
    end
    if (noise > 0) acc += int'($urandom_range(2 * noise)) - noise;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[SAMPLE_W-1:0];
  endfunction

  // One segment of tones on the bins picked by the pattern
  task automatic send_tone(input logic [CHAR_W-1:0] pattern, input int amp_lo,
                           input int amp_hi, input int noise, input bit random_phase);
    for (int j = 0; j < TONE_BINS; j++) begin
      tone_amp[j]   = pattern[CHAR_W-1-j] ? int'($urandom_range(amp_hi, amp_lo)) : 0;
      tone_phase[j] = random_phase ? int'($urandom_range(PHASE_N - 1)) : 0;
    end
    for (int n = 0; n < SEGMENT_LENGTH; n++) send_sample(tone_sample(n, noise));
  endtask

  // One segment with a single nonzero sample at its start
  task automatic send_impulse(input logic signed [SAMPLE_W-1:0] value);
    send_sample(value);
    repeat (SEGMENT_LENGTH - 1) send_sample('0);
  endtask

  // Random segment: mostly tones, some noise and full-scale bursts
  task automatic send_random_segment();
    segment_kind_t kind;
    int            r;
    r    = $urandom_range(9);
    kind = (r < 7) ? SEG_TONE : (r < 9) ? SEG_NOISE : SEG_FULL_SCALE;
    case (kind)
      SEG_TONE: begin
        send_tone(CHAR_W'($urandom_range(255)), 600, 5000, $urandom_range(300), 1'b1);
      end
      SEG_NOISE: begin
        repeat (SEGMENT_LENGTH) send_sample(SAMPLE_W'($urandom_range(16'hFFFF)));
      end
      default: begin
        repeat (SEGMENT_LENGTH) send_sample($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
      end
    endcase
  endtask

  // Mostly mid-range thresholds, sometimes the extremes
  function automatic logic [THRESH_W-1:0] choose_threshold();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return THRESH_W'($urandom_range(2600, 800));
  endfunction

  // Random phase: segments with a new threshold every few
  task automatic run_phase();
    for (int i = 0; i < SEGMENTS_PER_PHASE; i++) begin
      if (i % SEGMENTS_PER_SETTING == 0) set_threshold(choose_threshold());
      send_random_segment();
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int waited;
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    cfg_write_enable  = 1'b0;
    cfg_write_data    = '0;
    send_idle_pct     = 8;
    recv_idle_pct     = 68;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset threshold, silence, full-scale DC, all-bin tone, A5 tone
    repeat (SEGMENT_LENGTH) send_sample('0);
    repeat (SEGMENT_LENGTH) send_sample(16'sh7FFF);
    repeat (SEGMENT_LENGTH) send_sample(16'sh8000);
    send_tone(8'hFF, 4095, 4095, 0, 1'b0);
    send_tone(8'hA5, 4000, 8000, 0, 1'b1);

    // Zero threshold: smallest impulses on either side of the truncation
    set_threshold('0);
    send_impulse(16'sd1);
    send_impulse(16'sd2);
    send_impulse(-16'sd2);

    // Largest threshold: even a full-scale tone stays below it
    set_threshold('1);
    send_tone(8'h80, 32767, 32767, 0, 1'b0);

    // Threshold one: impulses just at and just past the limit
    set_threshold(THRESH_W'(1));
    send_impulse(16'sd33);
    send_impulse(16'sd34);

    // Random part under three idling profiles
    run_phase();
    send_idle_pct = 68;
    recv_idle_pct = 8;
    run_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_threshold(choose_threshold());
    stall_requests++;
    repeat (6) send_random_segment();
    run_phase();

    // Drain
    samples_ch.valid <= 1'b0;
    waited = 0;
    while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (chk_failures == 0 && chk_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
